>>> rtl/noise_channel_lfsr_envelope_core_defines.svh
// ----------------------------------------------------------------------------
// noise channel assertion macros
// shared concurrent assertion forms for the channel checker
// ----------------------------------------------------------------------------
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_CORE_DEFINES_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define NCLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("noise channel check failed");

// next-cycle implication, off while in reset
`define NCLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("noise channel check failed");

`endif

>>> rtl/ncle_pkg.sv
// ----------------------------------------------------------------------------
// ncle_pkg
// shared types and constants of the noise channel
// ----------------------------------------------------------------------------
package ncle_pkg;

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int VOL_W  = 4;

  localparam int PRESCALE_TICKS = 4;
  localparam int PS_W = (PRESCALE_TICKS > 1) ? $clog2(PRESCALE_TICKS) : 1;

  localparam int QUEUE_DEPTH = 2;

  // bus command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREQ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENV   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEN   = 3'd4;

  // channel register window
  localparam logic [ADDR_W-1:0] ADDR_BASE = 16'hFF20;

  localparam logic [1:0] REG_LEN  = 2'd0;
  localparam logic [1:0] REG_ENV  = 2'd1;
  localparam logic [1:0] REG_POLY = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_FREQ,
    OP_ENV,
    OP_LEN
  } ncle_op_e;

  typedef struct packed {
    ncle_op_e          op;
    logic [1:0]        reg_sel;
    logic [DATA_W-1:0] data;
  } ncle_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ncle_qstat_t;

endpackage

>>> rtl/ncle_if.sv
// ----------------------------------------------------------------------------
// ncle_if
// valid/ready channels for bus commands and channel results
// ----------------------------------------------------------------------------
interface ncle_in_if;
  logic                        valid;
  logic                        ready;
  logic [ncle_pkg::CMD_W-1:0]  command;
  logic [ncle_pkg::ADDR_W-1:0] address;
  logic [ncle_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  output ready);
endinterface

interface ncle_out_if;
  logic                        valid;
  logic                        ready;
  logic [ncle_pkg::DATA_W-1:0] read_data;
  logic [ncle_pkg::VOL_W-1:0]  sample_level;
  logic                        channel_enabled;

  modport source (output valid, output read_data, output sample_level,
                  output channel_enabled, input ready);
  modport sink   (input valid, input read_data, input sample_level,
                  input channel_enabled, output ready);
endinterface

>>> rtl/ncle_front.sv
// ----------------------------------------------------------------------------
// ncle_front
// accepts bus beats and classifies them into channel operations
// ----------------------------------------------------------------------------
module ncle_front (
  ncle_in_if.sink               in_i,
  input  ncle_pkg::ncle_qstat_t qstat_i,
  output logic                  push_o,
  output ncle_pkg::ncle_op_t    op_o
);
  import ncle_pkg::*;

  logic hit;

  assign in_i.ready = ~qstat_i.full;
  assign push_o     = in_i.valid & ~qstat_i.full;

  // the four registers sit on one aligned window
  assign hit = (in_i.address[ADDR_W-1:2] == ADDR_BASE[ADDR_W-1:2]);

  always_comb begin
    op_o.reg_sel = in_i.address[1:0];
    op_o.data    = in_i.write_data;
    op_o.op      = OP_NONE;
    unique case (in_i.command)
      CMD_READ:  op_o.op = hit ? OP_READ : OP_NONE;
      CMD_WRITE: op_o.op = hit ? OP_WRITE : OP_NONE;
      CMD_FREQ:  op_o.op = OP_FREQ;
      CMD_ENV:   op_o.op = OP_ENV;
      CMD_LEN:   op_o.op = OP_LEN;
      default:   op_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/ncle_queue.sv
// ----------------------------------------------------------------------------
// ncle_queue
// short fifo of classified operations between front and back
// ----------------------------------------------------------------------------
module ncle_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ncle_pkg::ncle_op_t    push_data_i,
  input  logic                  pop_i,
  output ncle_pkg::ncle_op_t    pop_data_o,
  output ncle_pkg::ncle_qstat_t stat_o
);
  import ncle_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ncle_op_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/ncle_back.sv
// ----------------------------------------------------------------------------
// ncle_back
// channel state, lfsr, envelope and length logic with the result register
// ----------------------------------------------------------------------------
module ncle_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ncle_pkg::ncle_qstat_t qstat_i,
  input  ncle_pkg::ncle_op_t    op_i,
  output logic                  pop_o,
  ncle_out_if.source            out_o
);
  import ncle_pkg::*;

  localparam int PER_W = 18;
  localparam int LFSR_W = 15;

  logic [7:0]        len_load_q, len_load_d;
  logic [7:0]        env_q, env_d;
  logic [7:0]        poly_q, poly_d;
  logic [7:0]        ctrl_q, ctrl_d;
  logic              chan_on_q, chan_on_d;
  logic              len_on_q, len_on_d;
  logic [5:0]        len_cnt_q, len_cnt_d;
  logic [VOL_W-1:0]  vol_q, vol_d;
  logic [31:0]       step_q, step_d;
  logic [1:0]        r3_q, r3_d;
  logic [2:0]        r5_q, r5_d;
  logic [2:0]        r7_q, r7_d;
  logic [PER_W-1:0]  period_q, period_d;
  logic [PS_W-1:0]   ps_q, ps_d;
  logic [LFSR_W-1:0] shift_q, shift_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_rd_q;
  logic [VOL_W-1:0]  out_sample_q;
  logic              out_en_q;
  logic [DATA_W-1:0] rd_d;
  logic [2:0]        pace;

  function automatic logic [PER_W-1:0] period_value(input logic [7:0] poly);
    logic [PER_W-1:0] d;
    logic [3:0]       s;
    d = PER_W'(poly[2:0]);
    s = poly[7:4];
    if (poly[2:0] == 3'd0) begin
      period_value = (PER_W'(1) << s) >> 1;
    end else begin
      period_value = d << s;
    end
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v,
                                                  input logic seven_bit);
    logic             nb;
    logic [LFSR_W-1:0] n;
    nb = ~(v[0] ^ v[1]);
    n  = {nb, v[LFSR_W-1:1]};
    if (seven_bit) begin
      n[6] = nb;
    end
    lfsr_step = n;
  endfunction

  // step count divisible by pace, from low bits and small residues
  function automatic logic pace_hit(input logic [2:0] p, input logic [1:0] lo,
                                    input logic [1:0] m3, input logic [2:0] m5,
                                    input logic [2:0] m7);
    unique case (p)
      3'd1:    pace_hit = 1'b1;
      3'd2:    pace_hit = ~lo[0];
      3'd3:    pace_hit = (m3 == 2'd0);
      3'd4:    pace_hit = (lo == 2'd0);
      3'd5:    pace_hit = (m5 == 3'd0);
      3'd6:    pace_hit = ~lo[0] && (m3 == 2'd0);
      3'd7:    pace_hit = (m7 == 3'd0);
      default: pace_hit = 1'b0;
    endcase
  endfunction

  assign pop_o = ~qstat_i.empty & (~out_valid_q | out_o.ready);
  assign pace  = env_q[2:0];

  always_comb begin
    len_load_d = len_load_q;
    env_d      = env_q;
    poly_d     = poly_q;
    ctrl_d     = ctrl_q;
    chan_on_d  = chan_on_q;
    len_on_d   = len_on_q;
    len_cnt_d  = len_cnt_q;
    vol_d      = vol_q;
    step_d     = step_q;
    r3_d       = r3_q;
    r5_d       = r5_q;
    r7_d       = r7_q;
    period_d   = period_q;
    ps_d       = ps_q;
    shift_d    = shift_q;
    rd_d       = '0;

    unique case (op_i.op)
      OP_READ: begin
        unique case (op_i.reg_sel)
          REG_LEN:  rd_d = len_load_q;
          REG_ENV:  rd_d = env_q;
          REG_POLY: rd_d = poly_q;
          REG_CTRL: rd_d = ctrl_q;
          default:  rd_d = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (op_i.reg_sel)
          REG_LEN: len_load_d = op_i.data;
          REG_ENV: begin
            env_d = op_i.data;
            if (op_i.data[7:3] == 5'd0) begin
              chan_on_d = 1'b0;
            end
          end
          REG_POLY: poly_d = op_i.data;
          REG_CTRL: begin
            ctrl_d = op_i.data;
            if (op_i.data[7]) begin
              chan_on_d = 1'b1;
              vol_d     = env_q[7:4];
              period_d  = period_value(poly_q);
              step_d    = '0;
              r3_d      = '0;
              r5_d      = '0;
              r7_d      = '0;
              shift_d   = '0;
            end
            if (op_i.data[6]) begin
              len_on_d  = 1'b1;
              len_cnt_d = len_load_q[5:0];
            end
          end
          default: ;
        endcase
      end
      OP_FREQ: begin
        if (chan_on_q) begin
          if (ps_q == PS_W'(PRESCALE_TICKS - 1)) begin
            ps_d = '0;
            if (period_q == '0) begin
              shift_d  = lfsr_step(shift_q, poly_q[3]);
              period_d = period_value(poly_q);
            end else begin
              period_d = period_q - PER_W'(1);
            end
          end else begin
            ps_d = ps_q + PS_W'(1);
          end
        end
      end
      OP_ENV: begin
        if (chan_on_q && pace != 3'd0) begin
          step_d = step_q + 32'd1;
          // residues restart when the count wraps to zero
          if (step_q == '1) begin
            r3_d = '0;
            r5_d = '0;
            r7_d = '0;
          end else begin
            r3_d = (r3_q == 2'd2) ? 2'd0 : r3_q + 2'd1;
            r5_d = (r5_q == 3'd4) ? 3'd0 : r5_q + 3'd1;
            r7_d = (r7_q == 3'd6) ? 3'd0 : r7_q + 3'd1;
          end
          if (pace_hit(pace, step_d[1:0], r3_d, r5_d, r7_d)) begin
            if (env_q[3]) begin
              if (vol_q != '1) begin
                vol_d = vol_q + VOL_W'(1);
              end
            end else if (vol_q != '0) begin
              vol_d = vol_q - VOL_W'(1);
            end
          end
        end
      end
      OP_LEN: begin
        if (len_on_q && chan_on_q) begin
          if (len_cnt_q == 6'h3F) begin
            len_on_d  = 1'b0;
            chan_on_d = 1'b0;
          end else begin
            len_cnt_d = len_cnt_q + 6'd1;
          end
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_load_q  <= '0;
      env_q       <= '0;
      poly_q      <= '0;
      ctrl_q      <= '0;
      chan_on_q   <= 1'b0;
      len_on_q    <= 1'b0;
      len_cnt_q   <= '0;
      vol_q       <= '0;
      step_q      <= '0;
      r3_q        <= '0;
      r5_q        <= '0;
      r7_q        <= '0;
      period_q    <= '0;
      ps_q        <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        len_load_q <= len_load_d;
        env_q      <= env_d;
        poly_q     <= poly_d;
        ctrl_q     <= ctrl_d;
        chan_on_q  <= chan_on_d;
        len_on_q   <= len_on_d;
        len_cnt_q  <= len_cnt_d;
        vol_q      <= vol_d;
        step_q     <= step_d;
        r3_q       <= r3_d;
        r5_q       <= r5_d;
        r7_q       <= r7_d;
        period_q   <= period_d;
        ps_q       <= ps_d;
        shift_q    <= shift_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_rd_q     <= rd_d;
      out_sample_q <= (chan_on_d && shift_d[0]) ? vol_d : '0;
      out_en_q     <= chan_on_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = out_rd_q;
  assign out_o.sample_level    = out_sample_q;
  assign out_o.channel_enabled = out_en_q;

endmodule

>>> rtl/noise_channel_lfsr_envelope_core.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_core
// four-register noise channel with lfsr, envelope and length counter
// ----------------------------------------------------------------------------
// Every accepted beat gives exactly one result beat, in order. The channel
// takes one beat a cycle while the queue is not full and returns its result
// when the output side is free, through the two-entry operation queue and
// then the single execution stage that updates the channel state and loads
// the result register. The input keeps accepting while a result waits, until
// the queue is full; throughput is then set by the rate at which results are
// taken.
module noise_channel_lfsr_envelope_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ncle_in_if.sink    in_i,
  ncle_out_if.source out_o
);
  import ncle_pkg::*;

  ncle_qstat_t qstat;
  ncle_op_t    push_op;
  ncle_op_t    head_op;
  logic        push;
  logic        pop;

  ncle_front u_front (
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .op_o    (push_op)
  );

  ncle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .pop_i       (pop),
    .pop_data_o  (head_op),
    .stat_o      (qstat)
  );

  ncle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .op_i    (head_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> rtl/ncle_checker.sv
// ----------------------------------------------------------------------------
// ncle_checker
// port-level checks of the noise channel, bound to the top level
// ----------------------------------------------------------------------------
`include "noise_channel_lfsr_envelope_core_defines.svh"

module ncle_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ncle_pkg::DATA_W-1:0] out_read_data_i,
  input logic [ncle_pkg::VOL_W-1:0]  out_sample_level_i,
  input logic                        out_channel_enabled_i
);
  import ncle_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 2);

  logic [OCC_W-1:0] occ_q;
  logic             in_beat;
  logic             out_beat;

  assign in_beat  = in_valid_i & in_ready_i;
  assign out_beat = out_valid_i & out_ready_i;

  // beats accepted whose results are not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_beat && !out_beat) begin
      occ_q <= occ_q + OCC_W'(1);
    end else if (out_beat && !in_beat) begin
      occ_q <= occ_q - OCC_W'(1);
    end
  end

  `NCLE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `NCLE_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_read_data_i) && $stable(out_sample_level_i) && $stable(out_channel_enabled_i))
  `NCLE_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, out_valid_i, occ_q != '0)
  `NCLE_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OCC_W'(QUEUE_DEPTH + 1))
  `NCLE_ASSERT_IMP(a_silent_off, clk_i, rst_ni, out_valid_i && !out_channel_enabled_i, out_sample_level_i == '0)

endmodule

bind noise_channel_lfsr_envelope_core ncle_checker u_ncle_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_read_data_i       (out_o.read_data),
  .out_sample_level_i    (out_o.sample_level),
  .out_channel_enabled_i (out_o.channel_enabled)
);

>>> bench/noise_channel_lfsr_envelope_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_core_tb
// drives bus reads, writes and frequency, envelope and length ticks into the
// channel, mirrors the channel state in a scoreboard class and checks every
// result beat field by field, in order
// ----------------------------------------------------------------------------
import ncle_pkg::*;

typedef struct packed {
  logic [DATA_W-1:0] read_data;
  logic [VOL_W-1:0]  sample_level;
  logic              channel_enabled;
} chan_result_t;

class channel_tracker;
  logic [DATA_W-1:0] len_reg;
  logic [DATA_W-1:0] env_reg;
  logic [DATA_W-1:0] poly_reg;
  logic [DATA_W-1:0] ctrl_reg;
  bit                chan_on;
  bit                len_on;
  logic [5:0]        len_cnt;
  logic [VOL_W-1:0]  volume;
  logic [31:0]       env_steps;
  logic [17:0]       period_cnt;
  int unsigned       prescale_cnt;
  logic [14:0]       lfsr;
  chan_result_t      expected_results[$];
  int                errors;

  function new();
    len_reg      = '0;
    env_reg      = '0;
    poly_reg     = '0;
    ctrl_reg     = '0;
    chan_on      = 1'b0;
    len_on       = 1'b0;
    len_cnt      = '0;
    volume       = '0;
    env_steps    = '0;
    period_cnt   = '0;
    prescale_cnt = 0;
    lfsr         = '0;
    errors       = 0;
  endfunction

  function logic [17:0] reload_period();
    logic [31:0] p;
    // a divisor code of zero stands for one half
    if (poly_reg[2:0] == 3'd0) p = (32'd1 << poly_reg[7:4]) >> 1;
    else p = {29'd0, poly_reg[2:0]} << poly_reg[7:4];
    return p[17:0];
  endfunction

  function void step_lfsr();
    logic        fb;
    logic [15:0] wide;
    fb = ~(lfsr[0] ^ lfsr[1]);
    wide = {fb, lfsr};
    if (poly_reg[3]) wide[7] = fb;
    lfsr = wide[15:1];
  endfunction

  function void reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    if (addr[ADDR_W-1:2] != ADDR_BASE[ADDR_W-1:2]) return;
    case (addr[1:0])
      REG_LEN:  len_reg = val;
      REG_ENV: begin
        env_reg = val;
        if (val[7:3] == 5'd0) chan_on = 1'b0;
      end
      REG_POLY: poly_reg = val;
      default: begin
        ctrl_reg = val;
        // trigger acts before the length load
        if (val[7]) begin
          chan_on    = 1'b1;
          volume     = env_reg[7:4];
          period_cnt = reload_period();
          env_steps  = '0;
          lfsr       = '0;
        end
        if (val[6]) begin
          len_on  = 1'b1;
          len_cnt = len_reg[5:0];
        end
      end
    endcase
  endfunction

  function logic [DATA_W-1:0] reg_read(logic [ADDR_W-1:0] addr);
    if (addr[ADDR_W-1:2] != ADDR_BASE[ADDR_W-1:2]) return '0;
    case (addr[1:0])
      REG_LEN:  return len_reg;
      REG_ENV:  return env_reg;
      REG_POLY: return poly_reg;
      default:  return ctrl_reg;
    endcase
  endfunction

  function void freq_tick();
    if (!chan_on) return;
    prescale_cnt++;
    if (prescale_cnt < PRESCALE_TICKS) return;
    prescale_cnt = 0;
    if (period_cnt == '0) begin
      step_lfsr();
      period_cnt = reload_period();
    end else begin
      period_cnt = period_cnt - 1'b1;
    end
  endfunction

  function void envelope_tick();
    logic [31:0] pace;
    pace = {29'd0, env_reg[2:0]};
    if (!chan_on || pace == 0) return;
    env_steps = env_steps + 1;
    if (env_steps % pace != 0) return;
    if (env_reg[3]) begin
      if (volume != 4'hF) volume = volume + 1'b1;
    end else if (volume != 4'h0) begin
      volume = volume - 1'b1;
    end
  endfunction

  function void length_tick();
    if (!len_on || !chan_on) return;
    if (len_cnt == 6'h3F) begin
      len_on  = 1'b0;
      chan_on = 1'b0;
      return;
    end
    len_cnt = len_cnt + 1'b1;
  endfunction

  function void note_input(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
    chan_result_t res;
    res.read_data = '0;
    case (cmd)
      CMD_READ:  res.read_data = reg_read(addr);
      CMD_WRITE: reg_write(addr, data);
      CMD_FREQ:  freq_tick();
      CMD_ENV:   envelope_tick();
      CMD_LEN:   length_tick();
      default: ;
    endcase
    res.sample_level    = (chan_on && lfsr[0]) ? volume : '0;
    res.channel_enabled = chan_on;
    expected_results.push_back(res);
  endfunction

  function void check_result(logic [DATA_W-1:0] rd, logic [VOL_W-1:0] level, logic en);
    chan_result_t exp_res;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing expected: read_data %0h sample_level %0d enabled %0b",
             rd, level, en);
      errors++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (rd !== exp_res.read_data) begin
      $error("read_data: expected %0h, got %0h", exp_res.read_data, rd);
      errors++;
    end
    if (level !== exp_res.sample_level) begin
      $error("sample_level: expected %0d, got %0d", exp_res.sample_level, level);
      errors++;
    end
    if (en !== exp_res.channel_enabled) begin
      $error("channel_enabled: expected %0b, got %0b", exp_res.channel_enabled, en);
      errors++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module noise_channel_lfsr_envelope_core_tb;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_BEATS = 1225;
  localparam int DRAIN_BEAT   = 300;
  localparam int HOLD_BEAT    = 500;
  localparam int STEADY_FIRST = 800;
  localparam int STEADY_LAST  = 1000;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 5000;

  logic clk;
  logic rst_n;
  bit   no_idle;
  bit   hold_req;
  int   hold_left;
  int   stall_cycles;

  channel_tracker tracker;

  ncle_in_if  in_if ();
  ncle_out_if out_if ();

  noise_channel_lfsr_envelope_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] reg_addr(logic [1:0] sel);
    return ADDR_BASE | {{(ADDR_W-2){1'b0}}, sel};
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    if (!no_idle && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.address    <= addr;
    in_if.write_data <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.note_input(cmd, addr, data);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic rand_beat(output logic [CMD_W-1:0] cmd, output logic [ADDR_W-1:0] addr,
                           output logic [DATA_W-1:0] data);
    int unsigned pick;
    logic [1:0]  sel;
    pick = $urandom_range(99);
    addr = ADDR_W'($urandom_range(16'hFFFF));
    data = DATA_W'($urandom_range(8'hFF));
    if (pick < 8) cmd = CMD_READ;
    else if (pick < 24) cmd = CMD_WRITE;
    else if (pick < 70) cmd = CMD_FREQ;
    else if (pick < 84) cmd = CMD_ENV;
    else if (pick < 97) cmd = CMD_LEN;
    else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if ((cmd == CMD_READ || cmd == CMD_WRITE) && $urandom_range(99) < 88) begin
      pick = $urandom_range(99);
      if (pick < 35) sel = REG_CTRL;
      else if (pick < 55) sel = REG_POLY;
      else if (pick < 80) sel = REG_ENV;
      else sel = REG_LEN;
      addr = reg_addr(sel);
      if (cmd == CMD_WRITE) begin
        case (sel)
          REG_CTRL: begin
            data[7] = ($urandom_range(99) < 75);
            data[6] = ($urandom_range(99) < 40);
          end
          REG_POLY: begin
            // keep most periods short so the lfsr output moves
            if ($urandom_range(99) < 70) data[7:4] = 4'd0;
            if ($urandom_range(99) < 50) data[2:0] = 3'd0;
          end
          REG_ENV: begin
            if ($urandom_range(99) < 10) data[7:3] = 5'd0;
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic directed_beats();
    send_beat(CMD_READ, reg_addr(REG_LEN), 8'h00);
    send_beat(CMD_READ, reg_addr(REG_CTRL), 8'hFF);
    send_beat(CMD_READ, 16'h0000, 8'h00);
    send_beat(CMD_READ, 16'hFFFF, 8'hFF);
    // ticks while the channel is off
    send_beat(CMD_FREQ, 16'hFFFF, 8'hFF);
    send_beat(CMD_ENV, 16'h0000, 8'h00);
    send_beat(CMD_LEN, ADDR_BASE, 8'hAA);
    send_beat(CMD_SPARE_LO, reg_addr(REG_CTRL), 8'hFF);
    send_beat(CMD_SPARE_HI, reg_addr(REG_ENV), 8'h55);
    // writes just outside the register window
    send_beat(CMD_WRITE, ADDR_BASE - 16'd1, 8'hFF);
    send_beat(CMD_WRITE, ADDR_BASE + 16'd4, 8'hFF);
    send_beat(CMD_WRITE, reg_addr(REG_LEN), 8'hFF);
    send_beat(CMD_WRITE, reg_addr(REG_ENV), 8'hF9);
    send_beat(CMD_WRITE, reg_addr(REG_POLY), 8'h08);
    // trigger and length load together
    send_beat(CMD_WRITE, reg_addr(REG_CTRL), 8'hC0);
    send_beat(CMD_READ, reg_addr(REG_ENV), 8'h00);
    send_beat(CMD_READ, reg_addr(REG_POLY), 8'h00);
    send_beat(CMD_ENV, 16'h1234, 8'h00);
    send_beat(CMD_LEN, 16'h0000, 8'h00);
    send_beat(CMD_LEN, 16'h0000, 8'h00);
    send_beat(CMD_WRITE, reg_addr(REG_CTRL), 8'h80);
    // envelope with its upper five bits clear switches the channel off
    send_beat(CMD_WRITE, reg_addr(REG_ENV), 8'h07);
    send_beat(CMD_WRITE, reg_addr(REG_POLY), 8'hF7);
    send_beat(CMD_READ, reg_addr(REG_POLY), 8'h00);
    send_beat(CMD_WRITE, reg_addr(REG_LEN), 8'h00);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_result(out_if.read_data, out_if.sample_level, out_if.channel_enabled);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("noise_channel_lfsr_envelope_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    tracker           = new();
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    rst_n             = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_READ;
    in_if.address    <= '0;
    in_if.write_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    directed_beats();
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == DRAIN_BEAT) wait_drained();
      if (i == HOLD_BEAT) hold_req = 1'b1;
      no_idle = (i >= STEADY_FIRST && i < STEADY_LAST);
      rand_beat(cmd, addr, data);
      send_beat(cmd, addr, data);
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("noise_channel_lfsr_envelope_core_tb passed");
    end else begin
      $display("noise_channel_lfsr_envelope_core_tb failed");
    end
    $finish;
  end

endmodule

>>> noise_channel_lfsr_envelope_core.f
+incdir+rtl
rtl/ncle_pkg.sv
rtl/ncle_if.sv
rtl/ncle_front.sv
rtl/ncle_queue.sv
rtl/ncle_back.sv
rtl/noise_channel_lfsr_envelope_core.sv
rtl/ncle_checker.sv
bench/noise_channel_lfsr_envelope_core_tb.sv
